// File: sv/vertex_screen_projection_top_assert.svh
// assertion macros used by the port-level checker
`ifndef VERTEX_SCREEN_PROJECTION_TOP_ASSERT_SVH
`define VERTEX_SCREEN_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication, off while reset is low
`define VSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define VSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define VSP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vsp_pkg.sv
// shared widths, types, register codes and reset values of the projection block
package vsp_pkg;

    // field widths
    localparam int ENTRY_W   = 20;
    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 13;
    localparam int WORD_W    = 60;
    localparam int NUM_WORDS = 6;
    localparam int SCR_W     = 16;

    // constant w = 1 of the input point
    localparam int COORD_FRAC_BITS = 16;

    // datapath widths
    localparam int MUL_W     = ENTRY_W + COORD_W;
    localparam int CLIP_W    = MUL_W + 1;
    localparam int NUM_W     = CLIP_W + 1;
    localparam int MAG_W     = NUM_W - 1;
    localparam int DEN_W     = CLIP_W;
    localparam int MUL_SPLIT = 27;
    localparam int PP_LO_W   = MUL_SPLIT + SIZE_W;
    localparam int PP_HI_W   = MAG_W - MUL_SPLIT + SIZE_W;
    localparam int PROD_W    = MAG_W + SIZE_W;
    localparam int QUOT_W    = SCR_W;
    localparam int REM_W     = DEN_W + QUOT_W;
    localparam int DIV_STEPS = QUOT_W + 1;

    localparam int LANES  = 2;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd7;

    // reset: identity matrix, 640 x 480 viewport
    localparam logic [WORD_W-1:0] MWORD_RESET [NUM_WORDS] = '{
        60'd4096, 60'd4503599627370496, 60'd0, 60'd4294967296, 60'd0, 60'd4096
    };
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    // saturation limits
    localparam logic [SCR_W-1:0]  SCR_MAX      = 16'h7FFF;
    localparam logic [SCR_W-1:0]  SCR_MIN      = 16'h8000;
    localparam logic [QUOT_W-1:0] QUOT_NEG_LIM = 16'h8000;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [MUL_W-1:0]   t_mul;
    typedef logic signed [CLIP_W-1:0]  t_clip;
    typedef logic signed [NUM_W-1:0]   t_num;

    // per-point flags that ride alongside the division
    typedef struct packed {
        logic             vis;
        logic [LANES-1:0] neg;
    } t_side;

endpackage

// File: sv/vsp_point_if.sv
// input channel: one world point per beat
interface vsp_point_if import vsp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord world_x;
    t_coord world_y;
    t_coord world_z;

    modport source (output valid, output world_x, output world_y, output world_z,
                    input ready);
    modport sink   (input valid, input world_x, input world_y, input world_z,
                    output ready);
endinterface

// File: sv/vsp_pixel_if.sv
// output channel: one screen position per beat
interface vsp_pixel_if import vsp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    visible;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;

    modport source (output valid, output visible, output screen_x, output screen_y,
                    input ready);
    modport sink   (input valid, input visible, input screen_x, input screen_y,
                    output ready);
endinterface

// File: sv/vertex_screen_projection_top.sv
// vertex screen projection: matrix transform, clip test and viewport mapping
// throughput: one point per cycle while the output is not stalled
// the 17-stage restoring divider fixes most of the depth
// a stalled output holds the pipe, but an empty last stage still lets the pipe move up
// reset (i_rst_n low, synchronous) empties the pipe and output, loads the identity
// matrix and a 640 x 480 viewport
module vertex_screen_projection_top import vsp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    vsp_point_if.sink            i_point,
    vsp_pixel_if.source          o_pixel
);

    // stage map: 0 products, 1 partial sums, 2 clip coords, 3 clip test and numerators,
    // 4 magnitudes, 5 scale partial products, 6 scaled numerators, 7..23 divider, 24 saturate
    localparam int FRONT      = 7;
    localparam int PIPE_DEPTH = FRONT + DIV_STEPS + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_mword [NUM_WORDS];
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_mword[i] <= MWORD_RESET[i];
            end
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATRIX_0: r_mword[0] <= i_cfg_data;
                CFG_MATRIX_1: r_mword[1] <= i_cfg_data;
                CFG_MATRIX_2: r_mword[2] <= i_cfg_data;
                CFG_MATRIX_3: r_mword[3] <= i_cfg_data;
                CFG_MATRIX_4: r_mword[4] <= i_cfg_data;
                CFG_MATRIX_5: r_mword[5] <= i_cfg_data;
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // row-major entries, three to a word, lowest first; upper bits of the last word unused
    t_entry w_m [4][4];
    for (genvar e = 0; e < 16; e++) begin : g_entry
        assign w_m[e/4][e%4] = r_mword[e/3][ENTRY_W*(e%3) +: ENTRY_W];
    end

    logic [SIZE_W-1:0] w_scale [LANES];
    assign w_scale[LANE_X] = r_width;
    assign w_scale[LANE_Y] = r_height;

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] r_valid;
    logic                  r_out_valid;
    logic                  w_out_load;
    logic                  w_en;

    // output register takes a beat when empty or being drained
    assign w_out_load = !r_out_valid || o_pixel.ready;
    // the whole pipe moves unless a finished point in the last stage cannot leave
    assign w_en       = w_out_load || !r_valid[PIPE_DEPTH-1];
    assign i_point.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_point.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 0: the twelve entry by coordinate products
    // ------------------------------------------------------------------
    t_coord w_pt [3];
    assign w_pt[0] = i_point.world_x;
    assign w_pt[1] = i_point.world_y;
    assign w_pt[2] = i_point.world_z;

    t_mul r_prod [4][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= w_m[r][c] * w_pt[c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: pairwise sums, the translation column scaled by w = 1
    // ------------------------------------------------------------------
    t_clip r_sa [4];
    t_clip r_sb [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 4; r++) begin
                r_sa[r] <= CLIP_W'(r_prod[r][0]) + CLIP_W'(r_prod[r][1]);
                r_sb[r] <= CLIP_W'(r_prod[r][2]) + (CLIP_W'(w_m[r][3]) <<< COORD_FRAC_BITS);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: clip coordinates x, y, z, w
    // ------------------------------------------------------------------
    t_clip r_clip [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 4; r++) begin
                r_clip[r] <= r_sa[r] + r_sb[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: clip test, numerators x + w and w - y, denominator 2w
    // ------------------------------------------------------------------
    t_num              r_numer3 [LANES];
    logic              r_vis3;
    logic [DEN_W-1:0]  r_den3;
    logic              n_vis3;

    assign n_vis3 = (r_clip[3] > 0)
                 && (t_num'(r_clip[2]) >= -t_num'(r_clip[3]))
                 && (r_clip[2] <= r_clip[3]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_numer3[LANE_X] <= t_num'(r_clip[0]) + t_num'(r_clip[3]);
            r_numer3[LANE_Y] <= t_num'(r_clip[3]) - t_num'(r_clip[1]);
            r_vis3           <= n_vis3;
            // w is positive when it matters, so doubling drops only the sign bit
            r_den3           <= {r_clip[3][CLIP_W-2:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sign and magnitude of each numerator
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] r_mag [LANES];
    t_side            r_side4;
    logic [DEN_W-1:0] r_den4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_mag[l]     <= MAG_W'(r_numer3[l][NUM_W-1] ? -r_numer3[l] : r_numer3[l]);
                r_side4.neg[l] <= r_numer3[l][NUM_W-1];
            end
            r_side4.vis <= r_vis3;
            r_den4      <= r_den3;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: magnitude times viewport size, split in two partial products
    // ------------------------------------------------------------------
    logic [PP_LO_W-1:0] r_pp_lo [LANES];
    logic [PP_HI_W-1:0] r_pp_hi [LANES];
    t_side              r_side5;
    logic [DEN_W-1:0]   r_den5;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_pp_lo[l] <= PP_LO_W'(r_mag[l][MUL_SPLIT-1:0]) * PP_LO_W'(w_scale[l]);
                r_pp_hi[l] <= PP_HI_W'(r_mag[l][MAG_W-1:MUL_SPLIT]) * PP_HI_W'(w_scale[l]);
            end
            r_side5 <= r_side4;
            r_den5  <= r_den4;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: full scaled numerators
    // ------------------------------------------------------------------
    logic [LANES-1:0][PROD_W-1:0] r_scaled;
    t_side                        r_side6;
    logic [DEN_W-1:0]             r_den6;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_scaled[l] <= (PROD_W'(r_pp_hi[l]) << MUL_SPLIT) + PROD_W'(r_pp_lo[l]);
            end
            r_side6 <= r_side5;
            r_den6  <= r_den5;
        end
    end

    // ------------------------------------------------------------------
    // stages 7..23: floor division, flags travel alongside
    // ------------------------------------------------------------------
    logic [LANES-1:0]             w_ovf;
    logic [LANES-1:0][QUOT_W-1:0] w_quot;
    t_side                        r_dside [DIV_STEPS];

    vsp_div_pipe u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_scaled),
        .i_den  (r_den6),
        .o_ovf  (w_ovf),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= r_side6;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 24: sign, saturation, zero for hidden points
    // ------------------------------------------------------------------
    // negative side reaches -32768 exactly, beyond that it clamps
    function automatic logic [SCR_W-1:0] sat_coord(
        input logic              neg,
        input logic              ovf,
        input logic [QUOT_W-1:0] q
    );
        logic [SCR_W-1:0] res;
        if (!neg) begin
            res = (ovf || q[QUOT_W-1]) ? SCR_MAX : SCR_W'(q);
        end else begin
            res = (ovf || (q > QUOT_NEG_LIM)) ? SCR_MIN : SCR_W'(QUOT_W'(0) - q);
        end
        return res;
    endfunction

    t_side             w_dlast;
    logic [SCR_W-1:0]  n_sat [LANES];
    logic [SCR_W-1:0]  r_sat [LANES];
    logic              r_sat_vis;

    assign w_dlast = r_dside[DIV_STEPS-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_sat[l] = w_dlast.vis ? sat_coord(w_dlast.neg[l], w_ovf[l], w_quot[l]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sat     <= n_sat;
            r_sat_vis <= w_dlast.vis;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic             r_out_vis;
    logic [SCR_W-1:0] r_out_x;
    logic [SCR_W-1:0] r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_valid[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_vis <= r_sat_vis;
            r_out_x   <= r_sat[LANE_X];
            r_out_y   <= r_sat[LANE_Y];
        end
    end

    assign o_pixel.valid    = r_out_valid;
    assign o_pixel.visible  = r_out_vis;
    assign o_pixel.screen_x = r_out_x;
    assign o_pixel.screen_y = r_out_y;

endmodule

// File: sv/vsp_div_pipe.sv
// pipelined restoring divider, two lanes sharing one denominator, one quotient bit a stage after the first
module vsp_div_pipe import vsp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [LANES-1:0][PROD_W-1:0]  i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic [LANES-1:0]              o_ovf,
    output logic [LANES-1:0][QUOT_W-1:0]  o_quot
);

    logic [REM_W-1:0]  r_rem  [DIV_STEPS][LANES];
    logic [DEN_W-1:0]  r_den  [DIV_STEPS];
    logic              r_ovf  [DIV_STEPS][LANES];
    logic [QUOT_W-1:0] r_quot [DIV_STEPS][LANES];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        // first stage only checks for a quotient of 2^QUOT_W or more
        localparam int SHIFT = DIV_STEPS - 1 - k;
        localparam bit FIRST = (k == 0);

        logic [REM_W-1:0]  w_rem_in  [LANES];
        logic              w_ovf_in  [LANES];
        logic [QUOT_W-1:0] w_quot_in [LANES];
        logic [DEN_W-1:0]  w_den_in;
        logic [REM_W-1:0]  w_sub;
        logic              w_ge      [LANES];
        logic [REM_W-1:0]  n_rem     [LANES];
        logic              n_ovf     [LANES];
        logic [QUOT_W-1:0] n_quot    [LANES];

        if (FIRST) begin : g_first
            always_comb begin
                w_den_in = i_den;
                for (int l = 0; l < LANES; l++) begin
                    w_rem_in[l]  = REM_W'(i_num[l]);
                    w_ovf_in[l]  = 1'b0;
                    w_quot_in[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                w_den_in = r_den[k-1];
                for (int l = 0; l < LANES; l++) begin
                    w_rem_in[l]  = r_rem[k-1][l];
                    w_ovf_in[l]  = r_ovf[k-1][l];
                    w_quot_in[l] = r_quot[k-1][l];
                end
            end
        end

        assign w_sub = REM_W'(w_den_in) << SHIFT;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_ge[l]   = (w_rem_in[l] >= w_sub);
                n_ovf[l]  = w_ovf_in[l] || (FIRST && w_ge[l]);
                n_rem[l]  = (w_ge[l] && !FIRST) ? (w_rem_in[l] - w_sub) : w_rem_in[l];
                n_quot[l] = w_quot_in[l] | (QUOT_W'(w_ge[l] && !FIRST) << SHIFT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den_in;
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l]  <= n_rem[l];
                    r_ovf[k][l]  <= n_ovf[l];
                    r_quot[k][l] <= n_quot[l];
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_ovf[l]  = r_ovf[DIV_STEPS-1][l];
        assign o_quot[l] = r_quot[DIV_STEPS-1][l];
    end

endmodule

// File: sv/vsp_checker.sv
// port-level checker for the projection block and its bind
`include "vertex_screen_projection_top_assert.svh"

module vsp_checker import vsp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_visible,
    input logic [SCR_W-1:0] i_out_x,
    input logic [SCR_W-1:0] i_out_y
);

    // a stalled result beat stays and holds its payload
    `VSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_visible) && $stable(i_out_x) && $stable(i_out_y), "stalled result beat changed")

    // hidden points report the origin
    `VSP_ASSERT_NOW(a_hidden_zero, i_clk, i_rst_n, i_out_valid && !i_out_visible, (i_out_x == '0) && (i_out_y == '0), "hidden point with nonzero coordinates")

    // with nothing waiting at the output the pipe always takes a point
    `VSP_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // reset empties the output and opens the input
    `VSP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready, "output not empty after reset")

endmodule

bind vertex_screen_projection_top vsp_checker u_vsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_point.ready),
    .i_out_valid   (o_pixel.valid),
    .i_out_ready   (o_pixel.ready),
    .i_out_visible (o_pixel.visible),
    .i_out_x       (o_pixel.screen_x),
    .i_out_y       (o_pixel.screen_y)
);
